// File: rtl/dmt_pkg.sv
// Shared types and codes for the running median tracker.
package dmt_pkg;

    // Port word widths that do not follow the parameters
    localparam int unsigned IN_WIDTH     = 32;
    localparam int unsigned OUT_WIDTH    = 32;
    localparam int unsigned SUM_WIDTH    = 33;
    localparam int unsigned COUNT_WIDTH  = 7;
    localparam int unsigned STATUS_WIDTH = 2;

    // Operation codes carried on kind
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_ERASE  = 1'b1;

    // Status codes
    localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_FOUND = 2'd2;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic compare;    // latch compare flags against the incoming value
        logic do_insert;  // shift right from the insert point
        logic do_erase;   // shift left from the first matching copy
    } cell_cmd_t;

endpackage

// File: rtl/dmt_cell.sv
// One cell of the sorted chain: holds one value and its compare flags.
module dmt_cell
    import dmt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cell_cmd_t                    cmd,
    input  logic signed [DATA_WIDTH-1:0] probe,       // value compared on cmd.compare
    input  logic signed [DATA_WIDTH-1:0] insert_val,  // value written at the insert point
    input  logic                         left_valid,
    input  logic                         left_take,
    input  logic signed [DATA_WIDTH-1:0] left_value,
    input  logic                         right_valid,
    input  logic signed [DATA_WIDTH-1:0] right_value,
    output logic                         valid,
    output logic                         take,
    output logic                         match,
    output logic signed [DATA_WIDTH-1:0] value
);

    logic                         valid_reg, valid_next;
    logic                         take_reg;
    logic                         ge_reg;
    logic                         match_reg;
    logic signed [DATA_WIDTH-1:0] value_reg, value_next;

    // Next contents: shift right on insert, shift left on erase
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.do_insert)
        begin
            valid_next = valid_reg | left_valid;
            if (take_reg)
            begin
                value_next = left_take ? left_value : insert_val;
            end
        end
        else if (cmd.do_erase && ge_reg)
        begin
            valid_next = right_valid;
            value_next = right_value;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            take_reg  <= 1'b0;
            ge_reg    <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.compare)
            begin
                // an empty slot sorts above everything
                take_reg  <= !valid_reg || (value_reg > probe);
                ge_reg    <= valid_reg && (value_reg >= probe);
                match_reg <= valid_reg && (value_reg == probe);
            end
        end
    end

    // Stored value, only read where valid
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign take  = take_reg;
    assign match = match_reg;
    assign value = value_reg;

endmodule

// File: rtl/dynamic_median_tracker_core.sv
// Top level of the running median tracker: control, cell chain, median select.
//
//  channel | handshake          | fields
//  --------+--------------------+-----------------------------------------------
//  command | start high, busy low | kind, value
//  result  | done, one cycle    | median_low, median_high, median_sum,
//          |                    | element_count, status
//
// An accepted word first latches compare flags in every cell, then shifts the
// chain. busy is high for the shift only, so a new word may follow as soon as
// busy falls. done and the result word are registered together after the shift,
// through done_reg and done_out_reg. Reset empties the chain at once. done
// cannot be stalled.
module dynamic_median_tracker_core
    import dmt_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           kind,
    input  logic signed [IN_WIDTH-1:0]     value,
    output logic                           busy,
    output logic                           done,
    output logic signed [OUT_WIDTH-1:0]    median_low,
    output logic signed [OUT_WIDTH-1:0]    median_high,
    output logic signed [SUM_WIDTH-1:0]    median_sum,
    output logic        [COUNT_WIDTH-1:0]  element_count,
    output logic        [STATUS_WIDTH-1:0] status
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int EXT_W = ((DATA_WIDTH > OUT_WIDTH) ? DATA_WIDTH : OUT_WIDTH) + 1;

    logic                           accept;
    logic                           busy_reg;
    logic                           done_reg;
    logic                           kind_reg;
    logic signed [DATA_WIDTH-1:0]   probe;
    logic signed [DATA_WIDTH-1:0]   x_reg;
    logic [CW-1:0]                  count_reg, count_next;
    logic [STATUS_WIDTH-1:0]        stat_reg, stat_next;
    logic                           full;
    logic                           found;
    cell_cmd_t                      cmd;

    logic                           cell_valid [CAPACITY];
    logic                           cell_take  [CAPACITY];
    logic [CAPACITY-1:0]            cell_match;
    logic signed [DATA_WIDTH-1:0]   cell_value [CAPACITY];

    logic signed [DATA_WIDTH-1:0]   lo_val, hi_val;
    logic signed [EXT_W-1:0]        lo_ext, hi_ext, sum_ext;

    logic                           done_out_reg;
    logic signed [OUT_WIDTH-1:0]    lo_out_reg, hi_out_reg;
    logic signed [SUM_WIDTH-1:0]    sum_out_reg;
    logic [COUNT_WIDTH-1:0]         cnt_out_reg;
    logic [STATUS_WIDTH-1:0]        stat_out_reg;

    assign accept = start && !busy_reg;
    // low bits of the input word, sign extended to the store width
    assign probe  = DATA_WIDTH'(value);
    assign full   = (count_reg == CW'(CAPACITY));
    assign found  = |cell_match;

    // Command broadcast to the chain
    always_comb
    begin
        cmd.compare   = accept;
        cmd.do_insert = busy_reg && (kind_reg == KIND_INSERT) && !full;
        cmd.do_erase  = busy_reg && (kind_reg == KIND_ERASE) && found;
    end

    // Count and status after the shift
    always_comb
    begin
        count_next = count_reg;
        stat_next  = STATUS_OK;
        if (kind_reg == KIND_INSERT)
        begin
            if (full)
            begin
                stat_next = STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (found)
            begin
                count_next = count_reg - CW'(1);
            end
            else
            begin
                stat_next = STATUS_NOT_FOUND;
            end
        end
    end

    // Sequencing: accept, shift, report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            done_out_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            busy_reg     <= accept;
            done_reg     <= busy_reg;
            done_out_reg <= done_reg;
            if (busy_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Operand and status hold
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            x_reg    <= probe;
        end
        if (busy_reg)
        begin
            stat_reg <= stat_next;
        end
    end

    // Chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                         lv, lt, rv;
        logic signed [DATA_WIDTH-1:0] lval, rval;

        if (i == 0)
        begin : g_first
            assign lv   = 1'b1;
            assign lt   = 1'b0;
            assign lval = '0;
        end
        else
        begin : g_mid_l
            assign lv   = cell_valid[i-1];
            assign lt   = cell_take[i-1];
            assign lval = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rv   = 1'b0;
            assign rval = '0;
        end
        else
        begin : g_mid_r
            assign rv   = cell_valid[i+1];
            assign rval = cell_value[i+1];
        end

        dmt_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .probe       (probe),
            .insert_val  (x_reg),
            .left_valid  (lv),
            .left_take   (lt),
            .left_value  (lval),
            .right_valid (rv),
            .right_value (rval),
            .valid       (cell_valid[i]),
            .take        (cell_take[i]),
            .match       (cell_match[i]),
            .value       (cell_value[i])
        );
    end

    // Median select: one-hot pick of the two middle cells by count
    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (count_reg != '0 && ((count_reg - CW'(1)) >> 1) == CW'(i))
            begin
                lo_val = lo_val | cell_value[i];
            end
            if (count_reg != '0 && (count_reg >> 1) == CW'(i))
            begin
                hi_val = hi_val | cell_value[i];
            end
        end
    end

    assign lo_ext  = EXT_W'(lo_val);
    assign hi_ext  = EXT_W'(hi_val);
    assign sum_ext = lo_ext + hi_ext;

    // Result word
    always_ff @(posedge clk)
    begin
        if (done_reg)
        begin
            lo_out_reg   <= lo_ext[OUT_WIDTH-1:0];
            hi_out_reg   <= hi_ext[OUT_WIDTH-1:0];
            sum_out_reg  <= sum_ext[SUM_WIDTH-1:0];
            cnt_out_reg  <= COUNT_WIDTH'(count_reg);
            stat_out_reg <= stat_reg;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_out_reg;
    assign median_low    = lo_out_reg;
    assign median_high   = hi_out_reg;
    assign median_sum    = sum_out_reg;
    assign element_count = cnt_out_reg;
    assign status        = stat_out_reg;

endmodule

// File: rtl/dmt_checker.sv
// Port-level checks for the running median tracker, bound to the top level.
module dmt_checker
    import dmt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic signed [SUM_WIDTH-1:0]    median_sum,
    input logic        [COUNT_WIDTH-1:0]  element_count,
    input logic        [STATUS_WIDTH-1:0] status
);

    // Every accepted word is followed by a result strobe on done
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted word produced no result");

    // Results never come back to back
    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

    // A dropped insert only happens on a full store
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_FULL) |-> (element_count == COUNT_WIDTH'(CAPACITY)))
        else $error("full status with store not full");

    // An empty store reports a zero median
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && element_count == '0) |-> (median_sum == '0))
        else $error("empty store with nonzero median");

endmodule

bind dynamic_median_tracker_core dmt_checker #(
    .CAPACITY(CAPACITY)
) u_dmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .median_sum    (median_sum),
    .element_count (element_count),
    .status        (status)
);
